FILE: src/sacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup package
// Shared types and constants for the cache lookup core.
// ----------------------------------------------------------------------------
package sacl_pkg;

	localparam int TAG_W     = 30;
	localparam int STAMP_W   = 32;
	localparam int COUNT_W   = 32;
	localparam int ADDRESS_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

	localparam logic [3:0] INDEX_BITS_RST  = 4'd10;
	localparam logic [3:0] OFFSET_BITS_RST = 4'd2;
	localparam logic [2:0] WAYS_RST        = 3'd1;
	localparam logic [3:0] OFFSET_BITS_MIN = 4'd2;
	localparam logic [3:0] OFFSET_BITS_MAX = 4'd8;

	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} sacl_line_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SPLIT,
		S_SCAN,
		S_WRITE
	} sacl_state_t;

endpackage

FILE: src/sacl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache lookup channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface sacl_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;

	modport source (output valid, output address, input ready);
	modport sink (input valid, input address, output ready);
endinterface

interface sacl_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [1:0]  way_used;
	logic [9:0]  set_index;
	logic [29:0] line_tag;
	logic [31:0] hit_total;
	logic [31:0] miss_total;

	modport source (output valid, output hit, output way_used, output set_index,
		output line_tag, output hit_total, output miss_total, input ready);
	modport sink (input valid, input hit, input way_used, input set_index,
		input line_tag, input hit_total, input miss_total, output ready);
endinterface

interface sacl_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/set_assoc_cache_lru_lookup_core.sv
`timescale 1ns / 1ps
// The ways of a set are read one per cycle through the read port of the line RAM,
// in order from way 0; the scan ends at the first hit or at the last configured way.
// The core handles one lookup at a time and takes a request beat only while idle.
// Reset: asynchronous, active low; a clearing pass zeroes all 2^(SET_BITS+WAY_W)
// lines (4096 by default) of the line RAM before the first request beat.
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup core
// Looks up each address in a set-associative tag store with LRU replacement.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_core #(
	parameter int SET_BITS = 10,
	parameter int MAX_WAYS = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	sacl_cfg_if.sink  cfg,
	sacl_in_if.sink   req,
	sacl_out_if.source rsp
);

	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int ADDR_W = SET_BITS + WAY_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int LINE_W = $bits(sacl_pkg::sacl_line_t);

	sacl_pkg::sacl_state_t state_q, state_d;

	logic [3:0]  index_bits_q;
	logic [3:0]  offset_bits_q;
	logic [2:0]  ways_q;

	logic [ADDR_W-1:0]               clr_q;
	logic [sacl_pkg::ADDRESS_W-1:0]  addr_q;
	logic [SET_BITS-1:0]             set_q;
	logic [sacl_pkg::TAG_W-1:0]      tag_q;
	logic [SET_BITS-1:0]             split_set;
	logic [sacl_pkg::TAG_W-1:0]      split_tag;
	logic [WAY_W-1:0]                last_q, last_d;
	logic [sacl_pkg::STAMP_W-1:0]    stamp_q;

	logic [WAY_W-1:0]             rd_way_q;
	logic                         rd_done_q;
	logic                         cmp_vld_s1;
	logic [WAY_W-1:0]             cmp_way_s1;
	logic                         inv_found_q, inv_found_d;
	logic [WAY_W-1:0]             inv_way_q, inv_way_d;
	logic [WAY_W-1:0]             best_way_q, best_way_d;
	logic [sacl_pkg::STAMP_W-1:0] best_stamp_q, best_stamp_d;
	logic [WAY_W-1:0]             chosen_q, chosen_d;
	logic                         hit_q;

	logic cmp_hit, new_inv, better, scan_end;
	logic load_out;

	logic                      ram_we, ram_re;
	logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
	logic [LINE_W-1:0]         ram_wdata, ram_rdata;
	sacl_pkg::sacl_line_t      line_rd, line_wr;

	logic [sacl_pkg::COUNT_W-1:0] hit_cnt_q, miss_cnt_q;
	logic                         out_valid_q;
	logic                         out_hit_q;
	logic [1:0]                   out_way_q;
	logic [9:0]                   out_set_q;
	logic [sacl_pkg::TAG_W-1:0]   out_tag_q;
	logic [31:0]                  way_wide, set_wide;

	sacl_split #(.SET_BITS(SET_BITS)) u_split (
		.address     (addr_q),
		.index_bits  (index_bits_q),
		.offset_bits (offset_bits_q),
		.set_index   (split_set),
		.line_tag    (split_tag)
	);

	sacl_ram #(.WIDTH(LINE_W), .DEPTH(DEPTH)) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == sacl_pkg::S_IDLE);

	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = out_hit_q;
	assign rsp.way_used   = out_way_q;
	assign rsp.set_index  = out_set_q;
	assign rsp.line_tag   = out_tag_q;
	assign rsp.hit_total  = hit_cnt_q;
	assign rsp.miss_total = miss_cnt_q;

	assign line_rd   = sacl_pkg::sacl_line_t'(ram_rdata);
	assign ram_raddr = {set_q, rd_way_q};
	assign way_wide  = 32'(chosen_q);
	assign set_wide  = 32'(set_q);

	always_comb begin
		if (ways_q == 3'd0) begin
			last_d = '0;
		end else if (int'(ways_q) > MAX_WAYS) begin
			last_d = WAY_W'(MAX_WAYS - 1);
		end else begin
			last_d = WAY_W'(ways_q - 3'd1);
		end
	end

	// Scan datapath: one way is compared per cycle.
	always_comb begin
		cmp_hit  = cmp_vld_s1 && line_rd.valid && (line_rd.tag == tag_q);
		new_inv  = cmp_vld_s1 && !line_rd.valid && !inv_found_q;
		better   = cmp_vld_s1 && line_rd.valid &&
			((cmp_way_s1 == '0) || (line_rd.stamp < best_stamp_q));
		scan_end = cmp_vld_s1 && (cmp_hit || (cmp_way_s1 == last_q));
		inv_found_d  = inv_found_q || new_inv;
		inv_way_d    = new_inv ? cmp_way_s1 : inv_way_q;
		best_way_d   = better ? cmp_way_s1 : best_way_q;
		best_stamp_d = better ? line_rd.stamp : best_stamp_q;
		if (cmp_hit) begin
			chosen_d = cmp_way_s1;
		end else if (inv_found_d) begin
			chosen_d = inv_way_d;
		end else begin
			chosen_d = best_way_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_re    = 1'b0;
		load_out  = 1'b0;
		line_wr.valid = 1'b1;
		line_wr.tag   = tag_q;
		line_wr.stamp = stamp_q;
		case (state_q)
			sacl_pkg::S_CLEAR: begin
				ram_we        = 1'b1;
				ram_waddr     = clr_q;
				line_wr       = '0;
				if (clr_q == '1) begin
					state_d = sacl_pkg::S_IDLE;
				end
			end
			sacl_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = sacl_pkg::S_SPLIT;
				end
			end
			sacl_pkg::S_SPLIT: begin
				state_d = sacl_pkg::S_SCAN;
			end
			sacl_pkg::S_SCAN: begin
				ram_re = !rd_done_q;
				if (scan_end) begin
					state_d = sacl_pkg::S_WRITE;
				end
			end
			sacl_pkg::S_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = {set_q, chosen_q};
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = sacl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sacl_pkg::S_IDLE;
			end
		endcase
		ram_wdata = LINE_W'(line_wr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= sacl_pkg::S_CLEAR;
			clr_q         <= '0;
			index_bits_q  <= sacl_pkg::INDEX_BITS_RST;
			offset_bits_q <= sacl_pkg::OFFSET_BITS_RST;
			ways_q        <= sacl_pkg::WAYS_RST;
			stamp_q       <= '0;
			hit_cnt_q     <= '0;
			miss_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
			cmp_vld_s1    <= 1'b0;
			rd_done_q     <= 1'b0;
			inv_found_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= ram_re;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					sacl_pkg::CFG_INDEX_BITS:  index_bits_q  <= cfg.data[3:0];
					sacl_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg.data[3:0];
					sacl_pkg::CFG_WAYS:        ways_q        <= cfg.data[2:0];
					default: begin
					end
				endcase
			end
			if (state_q == sacl_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (req.valid && req.ready) begin
				stamp_q     <= stamp_q + 1'b1;
				rd_done_q   <= 1'b0;
				inv_found_q <= 1'b0;
			end
			if (state_q == sacl_pkg::S_SCAN) begin
				inv_found_q <= inv_found_d;
				if (ram_re && (rd_way_q == last_q)) begin
					rd_done_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				hit_cnt_q   <= hit_cnt_q + {31'd0, hit_q};
				miss_cnt_q  <= miss_cnt_q + {31'd0, !hit_q};
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			addr_q   <= req.address;
			last_q   <= last_d;
			rd_way_q <= '0;
		end
		if (state_q == sacl_pkg::S_SPLIT) begin
			set_q <= split_set;
			tag_q <= split_tag;
		end
		if (state_q == sacl_pkg::S_SCAN) begin
			if (ram_re && (rd_way_q != last_q)) begin
				rd_way_q <= rd_way_q + 1'b1;
			end
			cmp_way_s1   <= rd_way_q;
			inv_way_q    <= inv_way_d;
			best_way_q   <= best_way_d;
			best_stamp_q <= best_stamp_d;
			if (scan_end) begin
				chosen_q <= chosen_d;
				hit_q    <= cmp_hit;
			end
		end
		if (load_out) begin
			out_hit_q <= hit_q;
			out_way_q <= way_wide[1:0];
			out_set_q <= set_wide[9:0];
			out_tag_q <= tag_q;
		end
	end

	a_one_count_per_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (hit_cnt_q + miss_cnt_q) == ($past(hit_cnt_q + miss_cnt_q) + 32'd1))
		else $error("hit and miss totals did not advance by one on a result");

	a_compare_within_ways: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sacl_pkg::S_SCAN) && cmp_vld_s1 |-> cmp_way_s1 <= last_q)
		else $error("scan compared a way beyond the configured ways");

	a_no_request_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sacl_pkg::S_CLEAR) |-> !(req.valid && req.ready))
		else $error("request beat accepted during the clearing pass");

	a_write_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sacl_pkg::S_WRITE) |-> ($past(state_q) == sacl_pkg::S_SCAN) ||
			($past(state_q) == sacl_pkg::S_WRITE))
		else $error("line write-back entered without a completed scan");

endmodule

FILE: src/sacl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/sacl_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address splitter
// Clamps the field widths and cuts an address into set index and tag.
// ----------------------------------------------------------------------------
module sacl_split #(
	parameter int SET_BITS = 10
) (
	input  logic [sacl_pkg::ADDRESS_W-1:0] address,
	input  logic [3:0]                     index_bits,
	input  logic [3:0]                     offset_bits,
	output logic [SET_BITS-1:0]            set_index,
	output logic [sacl_pkg::TAG_W-1:0]     line_tag
);

	logic [3:0]                     ib;
	logic [3:0]                     ob;
	logic [4:0]                     tag_shift;
	logic [sacl_pkg::ADDRESS_W-1:0] off_shifted;
	logic [sacl_pkg::ADDRESS_W-1:0] tag_shifted;
	logic [SET_BITS-1:0]            set_mask;

	always_comb begin
		if (int'(index_bits) > SET_BITS) begin
			ib = 4'(SET_BITS);
		end else begin
			ib = index_bits;
		end
		if (offset_bits < sacl_pkg::OFFSET_BITS_MIN) begin
			ob = sacl_pkg::OFFSET_BITS_MIN;
		end else if (offset_bits > sacl_pkg::OFFSET_BITS_MAX) begin
			ob = sacl_pkg::OFFSET_BITS_MAX;
		end else begin
			ob = offset_bits;
		end
		tag_shift   = {1'b0, ib} + {1'b0, ob};
		off_shifted = address >> ob;
		tag_shifted = address >> tag_shift;
		set_mask    = ~({SET_BITS{1'b1}} << ib);
		set_index   = off_shifted[SET_BITS-1:0] & set_mask;
		line_tag    = tag_shifted[sacl_pkg::TAG_W-1:0];
	end

endmodule

FILE: tb/set_assoc_cache_lru_lookup_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup core testbench
// Walks a short directed table of lookups and register writes, and then runs
// phases of random lookups under changing cache geometries and handshake
// pressure. Every response beat is checked against a typed or predicted result.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_core_test;
	import sacl_pkg::*;

	localparam int SET_BITS     = 10;
	localparam int MAX_WAYS     = 4;
	localparam int LINES        = (1 << SET_BITS) * MAX_WAYS;
	localparam int DRAIN_CYCLES = MAX_WAYS + 8;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 125;
	localparam int DIRECTED_ROWS = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic        hit;
		logic [1:0]  way_used;
		logic [9:0]  set_index;
		logic [29:0] line_tag;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} lookup_result_t;

	typedef enum logic {
		ROW_LOOKUP,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_index;
		logic [31:0]            value;
		logic                   typed;
		lookup_result_t         want;
	} row_t;

	typedef struct packed {
		logic [3:0] index_bits;
		logic [3:0] offset_bits;
		logic [2:0] ways;
	} geometry_t;

	logic clk = 1'b0;
	logic arst_n;

	sacl_cfg_if cfg ();
	sacl_in_if  req ();
	sacl_out_if rsp ();

	set_assoc_cache_lru_lookup_core #(
		.SET_BITS(SET_BITS),
		.MAX_WAYS(MAX_WAYS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// Predictor state: the tag store, the access stamp and the hit and miss counts.
	logic [3:0]  index_bits_q  = INDEX_BITS_RST;
	logic [3:0]  offset_bits_q = OFFSET_BITS_RST;
	logic [2:0]  ways_q        = WAYS_RST;
	bit          line_valid  [LINES];
	logic [29:0] line_tags   [LINES];
	logic [31:0] line_stamps [LINES];
	logic [31:0] access_count = '0;
	logic [31:0] hit_count    = '0;
	logic [31:0] miss_count   = '0;

	lookup_result_t pending_results[$];
	int mismatches = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	logic [9:0]  hot_sets [4];
	logic [29:0] hot_tags [6];

	row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h0000_0000, 1'b1,
			'{1'b0, 2'd0, 10'd0, 30'd0, 32'd0, 32'd1}},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h0000_0003, 1'b1,
			'{1'b1, 2'd0, 10'd0, 30'd0, 32'd1, 32'd1}},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'hFFFF_FFFF, 1'b1,
			'{1'b0, 2'd0, 10'h3FF, 30'hF_FFFF, 32'd1, 32'd2}},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h0000_1000, 1'b1,
			'{1'b0, 2'd0, 10'd0, 30'd1, 32'd1, 32'd3}},
		'{ROW_WRITE,  CFG_WAYS,        32'd4,         1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h0000_0000, 1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h0000_2000, 1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h0000_3000, 1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h0000_4000, 1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h0000_1000, 1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h0000_3000, 1'b0, '0},
		'{ROW_WRITE,  CFG_WAYS,        32'd0,         1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h0000_3000, 1'b0, '0},
		'{ROW_WRITE,  CFG_WAYS,        32'd7,         1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h0000_3000, 1'b0, '0},
		'{ROW_WRITE,  CFG_INDEX_BITS,  32'd0,         1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'hABCD_EF00, 1'b0, '0},
		'{ROW_WRITE,  CFG_INDEX_BITS,  32'd15,        1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h7FFF_FFFC, 1'b0, '0},
		'{ROW_WRITE,  CFG_OFFSET_BITS, 32'd0,         1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h0000_0004, 1'b0, '0},
		'{ROW_WRITE,  CFG_OFFSET_BITS, 32'd1,         1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h0000_0004, 1'b0, '0},
		'{ROW_WRITE,  CFG_OFFSET_BITS, 32'd15,        1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'hFFFF_FF00, 1'b0, '0},
		'{ROW_WRITE,  CFG_OFFSET_BITS, 32'd9,         1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h8000_0000, 1'b0, '0},
		'{ROW_WRITE,  CFG_OFFSET_BITS, 32'd8,         1'b0, '0},
		'{ROW_WRITE,  CFG_UNUSED,      32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'h5555_5555, 1'b0, '0},
		'{ROW_LOOKUP, CFG_INDEX_BITS, 32'hAAAA_AAAA, 1'b0, '0}
	};

	geometry_t geometries [PHASES] = '{
		'{4'd10, 4'd2,  3'd1},
		'{4'd10, 4'd2,  3'd4},
		'{4'd0,  4'd2,  3'd4},
		'{4'd15, 4'd8,  3'd4},
		'{4'd4,  4'd0,  3'd2},
		'{4'd3,  4'd9,  3'd3},
		'{4'd10, 4'd15, 3'd7},
		'{4'd6,  4'd1,  3'd0},
		'{4'd2,  4'd5,  3'd5},
		'{4'd11, 4'd8,  3'd1},
		'{4'd8,  4'd4,  3'd4},
		'{4'd10, 4'd2,  3'd4}
	};

	int sender_pct_by_mode   [4] = '{0, 56, 0, 12};
	int receiver_pct_by_mode [4] = '{0, 0, 56, 12};

	// Registers are clamped to the ranges that the tag store supports.
	function automatic void cache_layout(output int unsigned ib, output int unsigned ob,
			output int unsigned nw);
		ib = (index_bits_q > SET_BITS) ? SET_BITS : index_bits_q;
		ob = (offset_bits_q < OFFSET_BITS_MIN) ? OFFSET_BITS_MIN :
			((offset_bits_q > OFFSET_BITS_MAX) ? OFFSET_BITS_MAX : offset_bits_q);
		nw = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS) ? MAX_WAYS : ways_q);
	endfunction

	function automatic lookup_result_t predict_lookup(input logic [31:0] addr);
		int unsigned ib, ob, nw, base, pick;
		logic [9:0]  set_sel;
		logic [29:0] tag;
		logic        matched, found;
		logic [31:0] oldest;
		cache_layout(ib, ob, nw);
		set_sel = 10'((addr >> ob) & ((32'd1 << ib) - 32'd1));
		tag = 30'(addr >> (ib + ob));
		base = set_sel * MAX_WAYS;
		access_count = access_count + 32'd1;
		matched = 1'b0;
		pick = 0;
		for (int w = 0; w < nw; w++)
			if (!matched && line_valid[base + w] && line_tags[base + w] == tag) begin
				matched = 1'b1;
				pick = w;
			end
		if (matched) begin
			hit_count = hit_count + 32'd1;
		end else begin
			miss_count = miss_count + 32'd1;
			found = 1'b0;
			for (int w = 0; w < nw; w++)
				if (!found && !line_valid[base + w]) begin
					found = 1'b1;
					pick = w;
				end
			if (!found) begin
				oldest = line_stamps[base];
				pick = 0;
				for (int w = 1; w < nw; w++)
					if (line_stamps[base + w] < oldest) begin
						oldest = line_stamps[base + w];
						pick = w;
					end
			end
			line_tags[base + pick] = tag;
			line_valid[base + pick] = 1'b1;
		end
		line_stamps[base + pick] = access_count;
		return '{matched, 2'(pick), set_sel, tag, hit_count, miss_count};
	endfunction

	function automatic logic [31:0] pick_address();
		int unsigned ib, ob, nw;
		logic [31:0] block_offset;
		if ($urandom_range(99) < 20)
			return $urandom;
		cache_layout(ib, ob, nw);
		block_offset = $urandom & ((32'd1 << ob) - 32'd1);
		return (32'(hot_tags[$urandom_range(5)]) << (ib + ob)) |
			(32'(hot_sets[$urandom_range(3)]) << ob) | block_offset;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic settle();
		req.valid <= 1'b0;
		cfg.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			CFG_INDEX_BITS: begin
				index_bits_q = data[3:0];
			end
			CFG_OFFSET_BITS: begin
				offset_bits_q = data[3:0];
			end
			CFG_WAYS: begin
				ways_q = data[2:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_lookup(input logic [31:0] addr, input logic typed,
			input lookup_result_t want);
		lookup_result_t predicted;
		cfg.valid <= 1'b0;
		while ($urandom_range(99) < sender_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.address <= addr;
		do @(posedge clk); while (!req.ready);
		predicted = predict_lookup(addr);
		pending_results.push_back(typed ? want : predicted);
	endtask

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin : watch_responses
		lookup_result_t want;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("response beat with no lookup outstanding");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("hit", 32'(want.hit), 32'(rsp.hit));
				compare_field("way_used", 32'(want.way_used), 32'(rsp.way_used));
				compare_field("set_index", 32'(want.set_index), 32'(rsp.set_index));
				compare_field("line_tag", 32'(want.line_tag), 32'(rsp.line_tag));
				compare_field("hit_total", want.hit_total, rsp.hit_total);
				compare_field("miss_total", want.miss_total, rsp.miss_total);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		geometry_t g;
		for (int i = 0; i < LINES; i++) begin
			line_valid[i] = 1'b0;
			line_tags[i] = '0;
			line_stamps[i] = '0;
		end
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.address = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		sender_idle_pct = 12;
		receiver_stall_pct = 12;
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed_rows[r].kind == ROW_WRITE) begin
				settle();
				write_reg(directed_rows[r].reg_index, directed_rows[r].value);
			end else begin
				send_lookup(directed_rows[r].value, directed_rows[r].typed,
					directed_rows[r].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			int unsigned ib, ob, nw;
			g = geometries[p];
			settle();
			write_reg(CFG_INDEX_BITS, ($urandom << 4) | 32'(g.index_bits));
			write_reg(CFG_OFFSET_BITS, ($urandom << 4) | 32'(g.offset_bits));
			write_reg(CFG_WAYS, ($urandom << 3) | 32'(g.ways));
			write_reg(CFG_UNUSED, $urandom);
			cache_layout(ib, ob, nw);
			for (int s = 0; s < 4; s++)
				hot_sets[s] = 10'($urandom_range((1 << ib) - 1));
			for (int t = 0; t < 6; t++)
				hot_tags[t] = 30'($urandom);
			sender_idle_pct = sender_pct_by_mode[p % 4];
			receiver_stall_pct = receiver_pct_by_mode[p % 4];
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_lookup(pick_address(), 1'b0, '0);
		end

		settle();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
